// ===== sv/rqs_pkg.sv =====
package rqs_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int ID_BITS     = 10;
	localparam int BURST_BITS  = 8;
	localparam int PRIO_BITS   = 8;
	localparam int QUANT_BITS  = 8;
	localparam int MODE_BITS   = 2;
	localparam int ACT_BITS    = 2;
	localparam int SLOT_W      = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int OFF_W       = CNT_W + 1;
	localparam int CMP_W       = (BURST_BITS > QUANT_BITS) ? BURST_BITS : QUANT_BITS;
	localparam int ENTRY_W     = ID_BITS + BURST_BITS + PRIO_BITS;
	localparam int APB_AW      = 3;
	localparam int APB_DW      = 32;

	localparam logic [ACT_BITS-1:0] ACT_SUBMIT   = 2'd0;
	localparam logic [ACT_BITS-1:0] ACT_DISPATCH = 2'd1;

	localparam logic [MODE_BITS-1:0] POL_FIFO = 2'd0;
	localparam logic [MODE_BITS-1:0] POL_SJF  = 2'd1;
	localparam logic [MODE_BITS-1:0] POL_RR   = 2'd2;

	localparam logic [MODE_BITS-1:0]  MODE_RESET  = POL_RR;
	localparam logic [QUANT_BITS-1:0] QUANT_RESET = 8'd3;

	localparam logic REG_POLICY  = 1'b0;
	localparam logic REG_QUANTUM = 1'b1;

	typedef enum logic [1:0] {
		ST_ACCEPTED   = 2'd0,
		ST_DISPATCHED = 2'd1,
		ST_EMPTY      = 2'd2,
		ST_FULL       = 2'd3
	} status_t;

	typedef struct packed {
		logic [ID_BITS-1:0]    id;
		logic [BURST_BITS-1:0] burst;
		logic [PRIO_BITS-1:0]  prio;
	} entry_t;

	typedef struct packed {
		status_t               status;
		logic [ID_BITS-1:0]    pid;
		logic [BURST_BITS-1:0] run;
		logic [BURST_BITS-1:0] rem;
		logic                  fin;
		logic [PRIO_BITS-1:0]  prio;
		logic [CNT_W-1:0]      count;
	} result_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LATCH,
		OP_SUBMIT,
		OP_REJECT,
		OP_QUERY,
		OP_EMPTY,
		OP_FIFO,
		OP_RR,
		OP_SJF_INIT,
		OP_SCAN,
		OP_PREP,
		OP_SHIFT,
		OP_SJF_END
	} op_t;

	typedef struct packed {
		op_t  op;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic [ACT_BITS-1:0]  action;
		logic [MODE_BITS-1:0] policy;
		logic                 full;
		logic                 empty;
		logic                 scan_end;
		logic                 pick_edge;
		logic                 shift_last;
	} sts_t;

	function automatic logic [SLOT_W-1:0] slot_at(logic [SLOT_W-1:0] base,
			logic [OFF_W-1:0] off);
		logic [OFF_W:0] sum;
		sum = {{(OFF_W + 1 - SLOT_W){1'b0}}, base} + {1'b0, off};
		if (sum >= (OFF_W + 1)'(QUEUE_DEPTH)) begin
			sum = sum - (OFF_W + 1)'(QUEUE_DEPTH);
		end
		return sum[SLOT_W-1:0];
	endfunction

endpackage

// ===== sv/rqs_ram.sv =====
module rqs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== sv/rqs_dp.sv =====
module rqs_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [rqs_pkg::APB_AW-1:0]      paddr,
	input  logic [rqs_pkg::APB_DW-1:0]      pwdata,
	output logic [rqs_pkg::APB_DW-1:0]      prdata,
	input  logic [rqs_pkg::ACT_BITS-1:0]    action,
	input  logic [rqs_pkg::BURST_BITS-1:0]  burst_length,
	input  logic [rqs_pkg::PRIO_BITS-1:0]   priority_level,
	input  rqs_pkg::cmd_t                   cmd,
	output rqs_pkg::sts_t                   sts,
	output rqs_pkg::result_t                out_q
);

	import rqs_pkg::*;

	logic [CNT_W-1:0]      count_q;
	logic [SLOT_W-1:0]     head_q;
	logic [ID_BITS-1:0]    nid_q;
	logic [MODE_BITS-1:0]  policy_q;
	logic [QUANT_BITS-1:0] quantum_q;

	logic [ACT_BITS-1:0]   act_q;
	logic [BURST_BITS-1:0] burst_in_q;
	logic [PRIO_BITS-1:0]  prio_in_q;
	logic [CNT_W-1:0]      idx_q;
	logic [SLOT_W-1:0]     pick_q;
	entry_t                best_q;
	result_t               res_q;

	logic [OFF_W-1:0]      rd_off;
	logic [SLOT_W-1:0]     raddr;
	logic [ENTRY_W-1:0]    rdata;
	entry_t                rd;
	logic                  we;
	logic [SLOT_W-1:0]     waddr;
	entry_t                wdata;
	logic [CMP_W-1:0]      q_eff;
	logic                  rr_more;
	logic [BURST_BITS-1:0] rr_rem;
	logic [CNT_W-1:0]      cnt_inc;
	logic [CNT_W-1:0]      cnt_dec;
	logic [SLOT_W-1:0]     head_inc;
	logic                  cfg_wr;
	result_t               sjf_res;

	assign rd       = entry_t'(rdata);
	assign cnt_inc  = count_q + 1'b1;
	assign cnt_dec  = count_q - 1'b1;
	assign head_inc = slot_at(head_q, OFF_W'(1));
	assign q_eff    = (quantum_q == '0) ? CMP_W'(1) : CMP_W'(quantum_q);
	assign rr_more  = CMP_W'(rd.burst) > q_eff;
	assign rr_rem   = rd.burst - q_eff[BURST_BITS-1:0];
	assign cfg_wr   = psel & penable & pwrite;

	assign sjf_res = '{status: ST_DISPATCHED, pid: best_q.id, run: best_q.burst, rem: '0,
		fin: 1'b1, prio: best_q.prio, count: cnt_dec};

	always_comb begin
		unique case (cmd.op)
			OP_SJF_INIT: rd_off = OFF_W'(1);
			OP_SCAN:     rd_off = OFF_W'(idx_q) + OFF_W'(1);
			OP_PREP:     rd_off = OFF_W'(pick_q) + OFF_W'(1);
			OP_SHIFT:    rd_off = OFF_W'(idx_q) + OFF_W'(2);
			default:     rd_off = '0;
		endcase
	end

	assign raddr = slot_at(head_q, rd_off);

	always_comb begin
		we    = 1'b0;
		waddr = slot_at(head_q, OFF_W'(count_q));
		wdata = '{id: nid_q, burst: burst_in_q, prio: prio_in_q};
		unique case (cmd.op)
			OP_SUBMIT: we = 1'b1;
			OP_RR: begin
				we    = rr_more;
				wdata = '{id: rd.id, burst: rr_rem, prio: rd.prio};
			end
			OP_SHIFT: begin
				we    = 1'b1;
				waddr = slot_at(head_q, OFF_W'(idx_q));
				wdata = rd;
			end
			default: ;
		endcase
	end

	rqs_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(QUEUE_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign sts.action     = act_q;
	assign sts.policy     = policy_q;
	assign sts.full       = count_q == CNT_W'(QUEUE_DEPTH);
	assign sts.empty      = count_q == '0;
	assign sts.scan_end   = idx_q == count_q;
	assign sts.pick_edge  = (pick_q == '0) || (CNT_W'(pick_q) == cnt_dec);
	assign sts.shift_last = (OFF_W'(idx_q) + OFF_W'(2)) == OFF_W'(count_q);

	always_comb begin
		prdata = '0;
		if (paddr[APB_AW-1] == REG_POLICY) begin
			prdata = APB_DW'(policy_q);
		end else begin
			prdata = APB_DW'(quantum_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			head_q    <= '0;
			nid_q     <= '0;
			policy_q  <= MODE_RESET;
			quantum_q <= QUANT_RESET;
		end else begin
			if (cfg_wr) begin
				if (paddr[APB_AW-1] == REG_QUANTUM) begin
					quantum_q <= pwdata[QUANT_BITS-1:0];
				end else begin
					policy_q <= pwdata[MODE_BITS-1:0];
				end
			end
			unique case (cmd.op)
				OP_SUBMIT: begin
					count_q <= cnt_inc;
					nid_q   <= nid_q + 1'b1;
				end
				OP_FIFO: begin
					head_q  <= head_inc;
					count_q <= cnt_dec;
				end
				OP_RR: begin
					head_q <= head_inc;
					if (!rr_more) begin
						count_q <= cnt_dec;
					end
				end
				OP_SJF_END: begin
					if (pick_q == '0) begin
						head_q <= head_inc;
					end
					count_q <= cnt_dec;
				end
				OP_SHIFT: begin
					if (sts.shift_last) begin
						count_q <= cnt_dec;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LATCH: begin
				act_q      <= action;
				burst_in_q <= burst_length;
				prio_in_q  <= priority_level;
			end
			OP_SUBMIT: res_q <= '{status: ST_ACCEPTED, pid: nid_q, run: '0, rem: '0,
				fin: 1'b0, prio: '0, count: cnt_inc};
			OP_REJECT: res_q <= '{status: ST_FULL, pid: '0, run: '0, rem: '0,
				fin: 1'b0, prio: '0, count: count_q};
			OP_QUERY: res_q <= '{status: ST_ACCEPTED, pid: '0, run: '0, rem: '0,
				fin: 1'b0, prio: '0, count: count_q};
			OP_EMPTY: res_q <= '{status: ST_EMPTY, pid: '0, run: '0, rem: '0,
				fin: 1'b0, prio: '0, count: count_q};
			OP_FIFO: res_q <= '{status: ST_DISPATCHED, pid: rd.id, run: rd.burst, rem: '0,
				fin: 1'b1, prio: rd.prio, count: cnt_dec};
			OP_RR: begin
				if (rr_more) begin
					res_q <= '{status: ST_DISPATCHED, pid: rd.id,
						run: q_eff[BURST_BITS-1:0], rem: rr_rem, fin: 1'b0,
						prio: rd.prio, count: count_q};
				end else begin
					res_q <= '{status: ST_DISPATCHED, pid: rd.id, run: rd.burst, rem: '0,
						fin: 1'b1, prio: rd.prio, count: cnt_dec};
				end
			end
			OP_SJF_INIT: begin
				best_q <= rd;
				pick_q <= '0;
				idx_q  <= CNT_W'(1);
			end
			OP_SCAN: begin
				if (rd.burst < best_q.burst) begin
					best_q <= rd;
					pick_q <= idx_q[SLOT_W-1:0];
				end
				idx_q <= idx_q + 1'b1;
			end
			OP_PREP: idx_q <= CNT_W'(pick_q);
			OP_SHIFT: begin
				idx_q <= idx_q + 1'b1;
				if (sts.shift_last) begin
					res_q <= sjf_res;
				end
			end
			OP_SJF_END: res_q <= sjf_res;
			default: ;
		endcase
		if (cmd.out_load) begin
			out_q <= res_q;
		end
	end

endmodule

// ===== sv/rqs_ctrl.sv =====
module rqs_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	input  rqs_pkg::sts_t sts,
	output rqs_pkg::cmd_t cmd
);

	import rqs_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_DECIDE = 5'b00010,
		S_SCAN   = 5'b00100,
		S_SHIFT  = 5'b01000,
		S_DONE   = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	assign in_ready  = state_q == S_IDLE;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d      = state_q;
		cmd.op       = OP_NONE;
		cmd.out_load = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.op  = OP_LATCH;
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				state_d = S_DONE;
				priority if (sts.action == ACT_SUBMIT) begin
					cmd.op = sts.full ? OP_REJECT : OP_SUBMIT;
				end else if (sts.action == ACT_DISPATCH) begin
					priority if (sts.empty) begin
						cmd.op = OP_EMPTY;
					end else if (sts.policy == POL_RR) begin
						cmd.op = OP_RR;
					end else if (sts.policy == POL_SJF) begin
						cmd.op  = OP_SJF_INIT;
						state_d = S_SCAN;
					end else begin
						cmd.op = OP_FIFO;
					end
				end else begin
					cmd.op = OP_QUERY;
				end
			end
			S_SCAN: begin
				priority if (!sts.scan_end) begin
					cmd.op = OP_SCAN;
				end else if (sts.pick_edge) begin
					cmd.op  = OP_SJF_END;
					state_d = S_DONE;
				end else begin
					cmd.op  = OP_PREP;
					state_d = S_SHIFT;
				end
			end
			S_SHIFT: begin
				cmd.op = OP_SHIFT;
				if (sts.shift_last) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== sv/ready_queue_cpu_scheduler_unit.sv =====
// Sequence: an accepted request is latched, decoded and its result word registered; the word
// is shown once the output register is free, and only then is a new request taken. Shortest job
// first adds a scan of every entry and, when the pick is neither the oldest nor the newest entry,
// a compaction that moves each entry behind the pick one slot toward the head. The scan and
// the compaction use the single read port of the entry store, walked one slot a cycle.
// Reset: arst_n clears count, head, identifier counter and handshake state at once and loads
// policy 2 and quantum 3; the entry store is not cleared and needs no clearing pass.
module ready_queue_cpu_scheduler_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [rqs_pkg::APB_AW-1:0]      paddr,
	input  logic [rqs_pkg::APB_DW-1:0]      pwdata,
	output logic [rqs_pkg::APB_DW-1:0]      prdata,
	output logic                            pready,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [rqs_pkg::ACT_BITS-1:0]    action,
	input  logic [rqs_pkg::BURST_BITS-1:0]  burst_length,
	input  logic [rqs_pkg::PRIO_BITS-1:0]   priority_level,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [1:0]                      status,
	output logic [rqs_pkg::ID_BITS-1:0]     process_id,
	output logic [rqs_pkg::BURST_BITS-1:0]  run_length,
	output logic [rqs_pkg::BURST_BITS-1:0]  remaining_burst,
	output logic                            finished,
	output logic [rqs_pkg::PRIO_BITS-1:0]   priority_out,
	output logic [rqs_pkg::CNT_W-1:0]       queue_count
);

	import rqs_pkg::*;

	cmd_t    cmd;
	sts_t    sts;
	result_t out_q;

	assign pready = 1'b1;

	rqs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	rqs_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.action        (action),
		.burst_length  (burst_length),
		.priority_level(priority_level),
		.cmd           (cmd),
		.sts           (sts),
		.out_q         (out_q)
	);

	assign status          = out_q.status;
	assign process_id      = out_q.pid;
	assign run_length      = out_q.run;
	assign remaining_burst = out_q.rem;
	assign finished        = out_q.fin;
	assign priority_out    = out_q.prio;
	assign queue_count     = out_q.count;

endmodule
